// ===== sv/q4k_pkg.sv =====
// Q4K dequantizer package: payload structs, controller states, command struct,
// and the fp16 to fp32 helper function. No dependencies.
`timescale 1ns / 1ps
package q4k_pkg;

  localparam int unsigned BlockBytes  = 144;
  localparam int unsigned HeaderBytes = 16;
  localparam logic [31:0] CanonNan    = 32'h7FC0_0000;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       tensor_last;
  } q4k_in_t;

  typedef struct packed {
    logic [31:0] weight_bits;
    logic [7:0]  weight_index;
    logic        last_of_run;
    logic        tensor_done;
    logic        misalign_error;
  } q4k_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL,
    ST_SUB,
    ST_EMIT
  } q4k_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       take_byte;
    logic       load_prep;
    logic       load_mul;
    logic       load_sub;
    logic       emit_err;
    logic       high_pass;
    logic [4:0] lane;
  } q4k_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_header;
    logic is_misalign;
    logic chunk_end;
  } q4k_stat_t;

  // fp16 to fp32, exact. The subnormal normalization is a priority search
  // over ten bits only.
  function automatic logic [31:0] fp16_to_fp32(input logic [15:0] h);
    logic [4:0]  ex;
    logic [9:0]  mant;
    logic [31:0] f;
    logic [7:0]  e32;
    logic [9:0]  m;
    int          sh;
    ex   = h[14:10];
    mant = h[9:0];
    f    = {h[15], 31'd0};
    sh   = 0;
    m    = mant;
    if (ex == 5'd0) begin
      if (mant != 10'd0) begin
        for (int k = 9; k >= 0; k--) begin
          if (mant[k] && sh == 0) sh = 10 - k;
        end
        m   = 10'(mant << sh);
        e32 = 8'(113 - sh);
        f   = {h[15], e32, m, 13'd0};
      end
    end else if (ex == 5'h1F) begin
      f = {h[15], 8'hFF, mant, 13'd0};
    end else begin
      e32 = 8'({3'd0, ex} + 8'd112);
      f   = {h[15], e32, mant, 13'd0};
    end
    return f;
  endfunction

endpackage

// ===== sv/q4k_block_dequantizer.sv =====
// Top level of the Q4_K block dequantizer: controller plus datapath.
// Depends on q4k_pkg, q4k_ctrl and q4k_datapath.
//
//   channel   dir   handshake            payload
//   in_       in    in_valid/in_stall    q4k_in_t  (data_byte, tensor_last)
//   out_      out   out_valid/out_stall  q4k_out_t (weight, index, flags)
//
// A header byte is only stored; the controller stays idle. A quant byte is accepted,
// then goes through prepare, multiply, subtract and emit. The last byte of a chunk
// adds 32 more passes for its high-nibble weights.
// An early tensor end goes from the accepting cycle straight to the error beat.
// Reset clears the position and the controller; stored header bytes need none.
// Output stall holds the result in the emit state.
`timescale 1ns / 1ps
module q4k_block_dequantizer
  import q4k_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  q4k_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output q4k_out_t out_data
);

  q4k_cmd_t  cmd;
  q4k_stat_t stat;

  q4k_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall,
    .stat(stat), .cmd(cmd)
  );

  q4k_datapath u_dp (
    .clk, .rst_n, .in_beat(in_data), .cmd(cmd), .stat(stat), .res(out_data)
  );

  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input taken while a result waits");
  a_err_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.misalign_error) |-> (out_data.last_of_run
      && !out_data.tensor_done)) else $error("error beat flags wrong");
  a_done_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.tensor_done) |-> (out_data.weight_index == 8'd255))
    else $error("tensor done away from weight 255");

endmodule

// ===== sv/q4k_fmul.sv =====
// Exact-where-representable fp32 multiply with round to nearest even.
// Depends on q4k_pkg. One 24x24 mantissa product per call site, registered outside.
`timescale 1ns / 1ps
module q4k_fmul
  import q4k_pkg::*;
(
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] y
);

  logic        sa, sb, sy;
  logic [7:0]  ea, eb;
  logic [23:0] ma, mb;
  logic [47:0] p;
  logic [9:0]  ey;
  logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
  logic [7:0]  lza;
  logic [47:0] pn;
  logic signed [11:0] e_true;
  logic [24:0] mr;
  logic        g, st;
  logic [5:0]  dsh;
  logic [72:0] wide;

  always_comb begin
    sa = a[31]; sb = b[31]; sy = sa ^ sb;
    ea = a[30:23]; eb = b[30:23];
    a_nan  = (ea == 8'hFF) && (a[22:0] != 23'd0);
    b_nan  = (eb == 8'hFF) && (b[22:0] != 23'd0);
    a_inf  = (ea == 8'hFF) && (a[22:0] == 23'd0);
    b_inf  = (eb == 8'hFF) && (b[22:0] == 23'd0);
    a_zero = (ea == 8'd0) && (a[22:0] == 23'd0);
    b_zero = (eb == 8'd0) && (b[22:0] == 23'd0);
    ma = (ea == 8'd0) ? {1'b0, a[22:0]} : {1'b1, a[22:0]};
    mb = (eb == 8'd0) ? {1'b0, b[22:0]} : {1'b1, b[22:0]};
    p  = ma * mb;
    // Find leading one of the product.
    lza = 8'd0;
    for (int k = 0; k < 48; k++) begin
      if (p[k]) lza = 8'(47 - k);
    end
    pn  = p << lza;
    // Value = pn[47].pn[46:0] * 2^(e_true), e_true unbiased.
    e_true = 12'($signed({4'd0, (ea == 8'd0) ? 8'd1 : ea}))
           + 12'($signed({4'd0, (eb == 8'd0) ? 8'd1 : eb}))
           - 12'sd254 + 12'sd1 - 12'($signed({4'd0, lza}));
    ey   = 10'd0;
    mr   = 25'd0;
    g    = 1'b0;
    st   = 1'b0;
    dsh  = 6'd0;
    wide = 73'd0;
    y    = 32'd0;
    if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) begin
      y = CanonNan;
    end else if (a_inf || b_inf) begin
      y = {sy, 8'hFF, 23'd0};
    end else if (p == 48'd0) begin
      y = {sy, 31'd0};
    end else begin
      if (e_true < -12'sd126) begin
        // Subnormal result: shift right to fixed exponent -126.
        dsh  = (e_true < -12'sd176) ? 6'd50 : 6'(-12'sd126 - e_true);
        wide = {pn, 25'd0} >> dsh;
        mr   = {1'b0, wide[72:49]};
        g    = wide[48];
        st   = |wide[47:0];
        ey   = 10'd0;
      end else begin
        mr = {1'b0, pn[47:24]};
        g  = pn[23];
        st = |pn[22:0];
        ey = 10'(e_true + 12'sd127);
      end
      if (g && (st || mr[0])) mr = mr + 25'd1;
      if (mr[24]) begin
        mr = mr >> 1;
        ey = ey + 10'd1;
      end else if (ey == 10'd0 && mr[23]) begin
        ey = 10'd1;
      end
      if (ey >= 10'd255) y = {sy, 8'hFF, 23'd0};
      else               y = {sy, ey[7:0], mr[22:0]};
    end
  end

endmodule

// ===== sv/q4k_fsub.sv =====
// fp32 subtract a - b with round to nearest even and canonical NaN.
// Depends on q4k_pkg.
`timescale 1ns / 1ps
module q4k_fsub
  import q4k_pkg::*;
(
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] y
);

  logic        sa, sb, sx, sy, swp;
  logic [7:0]  ea, eb, ex, ez;
  logic [26:0] mx, mz, mzs;
  logic [27:0] sum;
  logic [7:0]  d;
  logic        stk;
  logic [4:0]  lz;
  logic signed [10:0] e;
  logic [27:0] n;
  logic [24:0] mr;
  logic        g, st;
  logic        a_nan, b_nan, a_inf, b_inf;

  always_comb begin
    sa = a[31]; sb = ~b[31];
    ea = a[30:23]; eb = b[30:23];
    a_nan = (ea == 8'hFF) && (a[22:0] != 23'd0);
    b_nan = (eb == 8'hFF) && (b[22:0] != 23'd0);
    a_inf = (ea == 8'hFF) && (a[22:0] == 23'd0);
    b_inf = (eb == 8'hFF) && (b[22:0] == 23'd0);
    swp = {eb, b[22:0]} > {ea, a[22:0]};
    sx = swp ? sb : sa;
    sy = swp ? sa : sb;
    ex = swp ? eb : ea;
    ez = swp ? ea : eb;
    mx = {(ex != 8'd0), (swp ? b[22:0] : a[22:0]), 3'd0};
    mz = {(ez != 8'd0), (swp ? a[22:0] : b[22:0]), 3'd0};
    d  = ((ex == 8'd0) ? 8'd1 : ex) - ((ez == 8'd0) ? 8'd1 : ez);
    stk = 1'b0;
    if (d > 8'd26) begin
      mzs = {26'd0, |mz};
    end else begin
      mzs = mz >> d;
      stk = |(mz & ~(27'h7FFFFFF << d));
      mzs[0] = mzs[0] | stk;
    end
    sum = (sx == sy) ? {1'b0, mx} + {1'b0, mzs} : {1'b0, mx} - {1'b0, mzs};
    lz = 5'd0;
    for (int k = 0; k < 28; k++) begin
      if (sum[k]) lz = 5'(27 - k);
    end
    e  = 11'($signed({3'd0, (ex == 8'd0) ? 8'd1 : ex})) + 11'sd1 - 11'($signed({6'd0, lz}));
    n  = sum << lz;
    if (e < 11'sd1) begin
      n = sum << (lz - 5'(11'sd1 - e));
      e = 11'sd0;
    end
    mr = {1'b0, n[27:4]};
    g  = n[3];
    st = |n[2:0];
    if (g && (st || mr[0])) mr = mr + 25'd1;
    if (mr[24]) begin
      mr = mr >> 1;
      e  = e + 11'sd1;
    end else if (e == 11'sd0 && mr[23]) begin
      e = 11'sd1;
    end
    if (a_nan || b_nan || (a_inf && b_inf && (sa != sb))) y = CanonNan;
    else if (a_inf) y = {sa, 8'hFF, 23'd0};
    else if (b_inf) y = {sb, 8'hFF, 23'd0};
    else if (sum == 28'd0) y = {(sx == sy) ? sx : 1'b0, 31'd0};
    else if (e >= 11'sd255) y = {sx, 8'hFF, 23'd0};
    else y = {sx, e[7:0], mr[22:0]};
  end

endmodule

// ===== sv/q4k_datapath.sv =====
// Datapath: block header and nibble storage, the scale/min decode and the
// weight arithmetic pipeline. Depends on q4k_pkg, q4k_fmul and q4k_fsub.
`timescale 1ns / 1ps
module q4k_datapath
  import q4k_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  q4k_in_t   in_beat,
  input  q4k_cmd_t  cmd,
  output q4k_stat_t stat,
  output q4k_out_t  res
);

  logic [7:0]  pos_r, pos_nxt;
  logic [15:0] d_half_r, m_half_r;
  logic [7:0]  scb_r [12];
  logic [3:0]  hi_r [32];
  logic [3:0]  lo_r;
  logic [1:0]  chunk_r;
  logic        end_r;
  logic [7:0]  off;
  logic [2:0]  sub;
  logic [5:0]  sc, mm;
  logic [3:0]  q;
  logic [31:0] dsub_r, msub_r, prod_r, res_w_r;
  logic [31:0] d_f, m_f, sc_f, m6_f, q_f, dsub_w, msub_w, prod_w, diff_w;
  logic [31:0] op_a, op_b, mul_y;
  logic [7:0]  idx_r;
  logic [7:0]  widx_r;
  logic [3:0]  q_r;
  logic        err_r, last_r, done_r;

  assign off = pos_r - 8'(HeaderBytes);
  assign stat.is_header   = pos_r < 8'(HeaderBytes);
  assign stat.is_misalign = in_beat.tensor_last && (pos_r != 8'(BlockBytes - 1));
  assign stat.chunk_end   = off[4:0] == 5'd31;

  always_comb begin
    pos_nxt = pos_r;
    if (cmd.take_byte) begin
      if (stat.is_misalign || pos_r == 8'(BlockBytes - 1)) pos_nxt = 8'd0;
      else pos_nxt = pos_r + 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= 8'd0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_byte && !stat.is_misalign) begin
      case (pos_r)
        8'd0: d_half_r[7:0]  <= in_beat.data_byte;
        8'd1: d_half_r[15:8] <= in_beat.data_byte;
        8'd2: m_half_r[7:0]  <= in_beat.data_byte;
        8'd3: m_half_r[15:8] <= in_beat.data_byte;
        default: begin
          if (stat.is_header) scb_r[4'(pos_r - 8'd4)] <= in_beat.data_byte;
          else hi_r[off[4:0]] <= in_beat.data_byte[7:4];
        end
      endcase
      lo_r    <= in_beat.data_byte[3:0];
      chunk_r <= off[6:5];
      idx_r   <= {off[6:5], 1'b0, off[4:0]};
      end_r   <= in_beat.tensor_last;
    end
  end

  // Sub-block scale and min decode for the current pass.
  always_comb begin
    sub = {chunk_r, cmd.high_pass};
    if (!sub[2]) begin
      sc = scb_r[{2'd0, sub[1:0]}][5:0];
      mm = scb_r[{2'd1, sub[1:0]}][5:0];
    end else begin
      sc = {scb_r[{2'd0, sub[1:0]}][7:6], scb_r[{2'd2, sub[1:0]}][3:0]};
      mm = {scb_r[{2'd1, sub[1:0]}][7:6], scb_r[{2'd2, sub[1:0]}][7:4]};
    end
    q = cmd.high_pass ? hi_r[cmd.lane] : lo_r;
  end

  function automatic logic [31:0] small_to_float(input logic [5:0] v);
    logic [31:0] f;
    f = 32'd0;
    for (int k = 0; k < 6; k++) begin
      if (v[k]) f = {1'b0, 8'(127 + k), 23'(({17'd0, v} << (23 - k)) & 23'h7FFFFF)};
    end
    return f;
  endfunction

  assign d_f  = fp16_to_fp32(d_half_r);
  assign m_f  = fp16_to_fp32(m_half_r);
  assign sc_f = small_to_float(sc);
  assign m6_f = small_to_float(mm);
  assign q_f  = small_to_float({2'd0, q_r});

  // Two multipliers for the sub-block factors, one for the quant product.
  q4k_fmul u_mul_d (.a(d_f), .b(sc_f), .y(dsub_w));
  q4k_fmul u_mul_m (.a(m_f), .b(m6_f), .y(msub_w));
  assign op_a = dsub_r;
  assign op_b = q_f;
  q4k_fmul u_mul_q (.a(op_a), .b(op_b), .y(mul_y));
  assign prod_w = mul_y;
  q4k_fsub u_sub (.a(prod_r), .b(msub_r), .y(diff_w));

  // The position has already moved on by the prepare step, so the chunk end of
  // the low pass comes from the captured index.
  always_ff @(posedge clk) begin
    if (cmd.load_prep) begin
      dsub_r <= dsub_w;
      msub_r <= msub_w;
      q_r    <= q;
      err_r  <= cmd.emit_err;
      last_r <= !cmd.high_pass ? (idx_r[4:0] != 5'd31) : (cmd.lane == 5'd31);
      done_r <= cmd.high_pass && (cmd.lane == 5'd31) && end_r;
      widx_r <= cmd.high_pass ? {chunk_r, 1'b1, cmd.lane} : idx_r;
    end
    if (cmd.load_mul) prod_r <= prod_w;
    if (cmd.load_sub) res_w_r <= diff_w;
  end

  always_comb begin
    res.weight_bits    = err_r ? 32'd0 : res_w_r;
    res.weight_index   = err_r ? 8'd0 : widx_r;
    res.last_of_run    = err_r ? 1'b1 : last_r;
    res.tensor_done    = err_r ? 1'b0 : done_r;
    res.misalign_error = err_r;
  end

endmodule

// ===== sv/q4k_ctrl.sv =====
// Controller: walks each quant byte through prepare, multiply, subtract and
// emit, and at a chunk end the 32 high-nibble weights. Depends on q4k_pkg.
`timescale 1ns / 1ps
module q4k_ctrl
  import q4k_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  q4k_stat_t  stat,
  output q4k_cmd_t   cmd
);

  q4k_state_t  state_r, state_nxt;
  logic        high_r, high_nxt;
  logic        err_r, err_nxt;
  logic        chend_r, chend_nxt;
  logic [4:0]  lane_r, lane_nxt;
  logic        take;

  assign take = (state_r == ST_IDLE) && in_valid;

  always_comb begin
    state_nxt = state_r;
    high_nxt  = high_r;
    err_nxt   = err_r;
    chend_nxt = chend_r;
    lane_nxt  = lane_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          high_nxt  = 1'b0;
          lane_nxt  = 5'd0;
          err_nxt   = stat.is_misalign;
          chend_nxt = stat.chunk_end;
          if (stat.is_misalign) state_nxt = ST_EMIT;
          else if (!stat.is_header) state_nxt = ST_PREP;
        end
      end
      ST_PREP: state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_SUB;
      ST_SUB:  state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (!out_stall) begin
          if (!err_r && !high_r && chend_r) begin
            high_nxt  = 1'b1;
            state_nxt = ST_PREP;
          end else if (!err_r && high_r && lane_r != 5'd31) begin
            lane_nxt  = lane_r + 5'd1;
            state_nxt = ST_PREP;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall      = state_r != ST_IDLE;
    out_valid     = state_r == ST_EMIT;
    cmd.take_byte = take;
    cmd.load_prep = (state_r == ST_PREP) || (take && stat.is_misalign);
    cmd.load_mul  = state_r == ST_MUL;
    cmd.load_sub  = state_r == ST_SUB;
    cmd.emit_err  = take && stat.is_misalign;
    cmd.high_pass = high_r;
    cmd.lane      = lane_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      high_r  <= 1'b0;
      err_r   <= 1'b0;
      chend_r <= 1'b0;
      lane_r  <= 5'd0;
    end else begin
      state_r <= state_nxt;
      high_r  <= high_nxt;
      err_r   <= err_nxt;
      chend_r <= chend_nxt;
      lane_r  <= lane_nxt;
    end
  end

endmodule

// ===== tb/q4k_dequant_checker.sv =====
// Scoreboard for the Q4_K block dequantizer: watches both channels, predicts
// every weight in fp32 and compares results in order. Depends on q4k_pkg.
`timescale 1ns / 1ps
module q4k_dequant_checker
  import q4k_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_stall,
  input  q4k_in_t  in_data,
  input  logic     out_valid,
  input  logic     out_stall,
  input  q4k_out_t out_data,
  output int       fail_count,
  output int       pending,
  output int       weights_seen
);

  q4k_out_t   weight_queue[$];
  int unsigned byte_pos;
  logic [15:0] scale_half;
  logic [15:0] min_half;
  logic [7:0]  scale_bytes[12];
  logic [3:0]  high_nibbles[32];

  // Splits an fp16 value into flags and its magnitude in units of 2^-24.
  function automatic void split_half(input logic [15:0] h, output bit is_nan,
                                     output bit is_inf, output longint mag);
    logic [4:0] ex;
    logic [9:0] mant;
    ex     = h[14:10];
    mant   = h[9:0];
    is_nan = 0;
    is_inf = 0;
    mag    = 0;
    if (ex == 5'h1F) begin
      is_nan = (mant != 0);
      is_inf = (mant == 0);
    end else if (ex == 0) begin
      mag = longint'(mant);
    end else begin
      mag = longint'(1024 + mant) << (ex - 1);
    end
  endfunction

  // Rounds a nonzero integer count of 2^-24 units to fp32, nearest even.
  function automatic logic [31:0] units_to_float(input longint diff);
    logic [63:0] a, keep, rem, half;
    int p, sh;
    bit s;
    s = diff < 0;
    a = s ? -diff : diff;
    p = 0;
    for (int k = 0; k < 63; k++) if (a[k]) p = k;
    if (p <= 23) begin
      keep = a << (23 - p);
    end else begin
      sh   = p - 23;
      keep = a >> sh;
      rem  = a & ((64'd1 << sh) - 1);
      half = 64'd1 << (sh - 1);
      if (rem > half || (rem == half && keep[0])) keep++;
      if (keep == (64'd1 << 24)) begin
        keep = keep >> 1;
        p++;
      end
    end
    return {s, 8'(p + 103), keep[22:0]};
  endfunction

  function automatic logic [31:0] dequant_weight(input int sub, input logic [3:0] q);
    int sc, m;
    bit dn, di, mn, mi, pnan, pinf, mnan, minf, ds, ms;
    longint dmag, mmag, prod, offs;
    if (sub < 4) begin
      sc = scale_bytes[sub] & 63;
      m  = scale_bytes[sub + 4] & 63;
    end else begin
      sc = (scale_bytes[sub + 4] & 4'hF) | ((scale_bytes[sub - 4] >> 6) << 4);
      m  = (scale_bytes[sub + 4] >> 4) | ((scale_bytes[sub] >> 6) << 4);
    end
    split_half(scale_half, dn, di, dmag);
    split_half(min_half, mn, mi, mmag);
    ds   = scale_half[15];
    ms   = min_half[15];
    pnan = dn || (di && (sc == 0 || q == 0));
    pinf = di && !pnan;
    mnan = mn || (mi && m == 0);
    minf = mi && !mnan;
    if (pnan || mnan || (pinf && minf && ds == ms)) return CanonNan;
    if (pinf) return {ds, 8'hFF, 23'd0};
    if (minf) return {~ms, 8'hFF, 23'd0};
    prod = dmag * sc * q;
    offs = mmag * m;
    if (ds) prod = -prod;
    if (ms) offs = -offs;
    // An exact zero is negative only for -0 minus +0.
    if (prod == offs)
      return (prod == 0 && ds && !ms) ? 32'h8000_0000 : 32'd0;
    return units_to_float(prod - offs);
  endfunction

  task automatic predict_byte(input q4k_in_t item);
    q4k_out_t w;
    int off, c, l;
    if (item.tensor_last && byte_pos != BlockBytes - 1) begin
      w = '0;
      w.last_of_run    = 1;
      w.misalign_error = 1;
      weight_queue.push_back(w);
      byte_pos = 0;
      return;
    end
    off      = int'(byte_pos) - int'(HeaderBytes);
    case (byte_pos)
      0: scale_half[7:0]  = item.data_byte;
      1: scale_half[15:8] = item.data_byte;
      2: min_half[7:0]    = item.data_byte;
      3: min_half[15:8]   = item.data_byte;
      default: begin
        if (byte_pos < HeaderBytes) scale_bytes[byte_pos - 4] = item.data_byte;
      end
    endcase
    byte_pos = (byte_pos == BlockBytes - 1) ? 0 : byte_pos + 1;
    if (off < 0) return;
    c = off >> 5;
    l = off & 31;
    high_nibbles[l] = item.data_byte[7:4];
    w = '0;
    w.weight_bits  = dequant_weight(2 * c, item.data_byte[3:0]);
    w.weight_index = 8'(c * 64 + l);
    w.last_of_run  = (l != 31);
    weight_queue.push_back(w);
    if (l == 31) begin
      for (int i = 0; i < 32; i++) begin
        w = '0;
        w.weight_bits  = dequant_weight(2 * c + 1, high_nibbles[i]);
        w.weight_index = 8'(c * 64 + 32 + i);
        w.last_of_run  = (i == 31);
        w.tensor_done  = (i == 31) && item.tensor_last;
        weight_queue.push_back(w);
      end
    end
  endtask

  always @(posedge clk) begin
    q4k_out_t exp_w;
    if (!rst_n) begin
      byte_pos      = 0;
      fail_count   <= 0;
      weights_seen <= 0;
      pending      <= 0;
      weight_queue.delete();
    end else begin
      if (out_valid && !out_stall) begin
        weights_seen <= weights_seen + 1;
        if (weight_queue.size() == 0) begin
          $error("unexpected result beat: %p", out_data);
          fail_count <= fail_count + 1;
        end else begin
          exp_w = weight_queue.pop_front();
          if (out_data !== exp_w) begin
            fail_count <= fail_count + 1;
            if (out_data.weight_bits !== exp_w.weight_bits)
              $error("weight_bits: expected %h, got %h", exp_w.weight_bits,
                     out_data.weight_bits);
            if (out_data.weight_index !== exp_w.weight_index)
              $error("weight_index: expected %0d, got %0d", exp_w.weight_index,
                     out_data.weight_index);
            if (out_data.last_of_run !== exp_w.last_of_run)
              $error("last_of_run: expected %b, got %b", exp_w.last_of_run,
                     out_data.last_of_run);
            if (out_data.tensor_done !== exp_w.tensor_done)
              $error("tensor_done: expected %b, got %b", exp_w.tensor_done,
                     out_data.tensor_done);
            if (out_data.misalign_error !== exp_w.misalign_error)
              $error("misalign_error: expected %b, got %b", exp_w.misalign_error,
                     out_data.misalign_error);
          end
        end
      end
      if (in_valid && !in_stall) predict_byte(in_data);
      pending <= weight_queue.size();
    end
  end

endmodule

// ===== tb/tb_q4k_block_dequantizer.sv =====
// Testbench top for the Q4_K block dequantizer: clock, reset, byte stream and
// result stalls, plus the verdict. Depends on q4k_pkg, q4k_block_dequantizer and q4k_dequant_checker.
`timescale 1ns / 1ps
module tb_q4k_block_dequantizer;
  import q4k_pkg::*;

  localparam int NumBytes   = 420;
  localparam int IdleLimit  = 5000;
  localparam int LongHold   = 600;

  logic     clk = 0;
  logic     rst_n = 0;
  logic     in_valid = 0;
  logic     in_stall;
  q4k_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 0;
  q4k_out_t out_data;
  int       fail_count, pending, weights_seen;
  int       bytes_sent = 0;
  int       blocks_done = 0;
  int       misaligned_ends = 0;
  int       idle_cycles = 0;

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  q4k_block_dequantizer dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  q4k_dequant_checker scoreboard (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .fail_count(fail_count), .pending(pending), .weights_seen(weights_seen)
  );

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Mostly ordinary scales, with zeros, subnormals, infinities and NaNs mixed in.
  function automatic logic [15:0] pick_half();
    int r;
    r = $urandom_range(0, 19);
    case (r)
      0: return 16'h0000;
      1: return 16'h8000;
      2: return 16'h7C00;
      3: return 16'hFC00;
      4: return {$urandom_range(0, 1) == 1, 5'h1F, 10'($urandom_range(1, 1023))};
      5: return {$urandom_range(0, 1) == 1, 5'h00, 10'($urandom_range(1, 1023))};
      6: return {$urandom_range(0, 1) == 1, 5'h1E, 10'h3FF};
      7: return 16'($urandom());
      default: return {$urandom_range(0, 1) == 1, 5'($urandom_range(6, 18)),
                       10'($urandom())};
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    int g;
    in_valid <= 1;
    in_data  <= '{data_byte: b, tensor_last: last};
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    bytes_sent++;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk);
    end
  endtask

  // One block; with abort_at below 144 the tensor ends early at that byte.
  task automatic send_block(input int abort_at, input bit mark_end);
    logic [15:0] d, dm;
    d  = pick_half();
    dm = pick_half();
    for (int p = 0; p < BlockBytes; p++) begin
      if (p == abort_at) begin
        send_byte(8'($urandom()), 1);
        misaligned_ends++;
        return;
      end
      case (p)
        0: send_byte(d[7:0], 0);
        1: send_byte(d[15:8], 0);
        2: send_byte(dm[7:0], 0);
        3: send_byte(dm[15:8], 0);
        default: send_byte(8'($urandom()), (p == BlockBytes - 1) && mark_end);
      endcase
    end
    blocks_done++;
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  // Result side: random stalls, one long hold once the first chunk is under way.
  initial begin
    int n;
    bit held;
    held = 0;
    @(posedge rst_n);
    forever begin
      if (!held && bytes_sent > 40) begin
        held = 1;
        out_stall <= 1;
        for (int k = 0; k < LongHold; k++) @(posedge clk);
      end
      n = gap_len();
      if (n > 0) begin
        out_stall <= 1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (rst_n && idle_cycles >= IdleLimit) begin
      $display("timeout with %0d results outstanding", pending);
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: early tensor ends at the first byte and inside the header,
    // then a full block that ends the tensor on its last byte.
    send_byte(8'hFF, 1);
    misaligned_ends++;
    for (int p = 0; p < 6; p++) send_byte(8'h00, 0);
    send_byte(8'hA5, 1);
    misaligned_ends++;
    send_block(BlockBytes, 1);
    wait_drained();

    // The last block is cut short so that the byte count lands on NumBytes.
    while (bytes_sent < NumBytes) begin
      if (NumBytes - bytes_sent < int'(BlockBytes))
        send_block(NumBytes - bytes_sent - 1, 0);
      else if ($urandom_range(0, 3) == 0)
        send_block($urandom_range(0, BlockBytes - 2), 0);
      else
        send_block(BlockBytes, $urandom_range(0, 1) == 1);
    end
    in_valid <= 0;

    wait_drained();
    $display("Sent %0d bytes: %0d complete blocks, %0d early tensor ends.",
             bytes_sent, blocks_done, misaligned_ends);
    $display("Checked %0d result beats, %0d mismatches.", weights_seen, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/q4k_pkg.sv
sv/q4k_fmul.sv
sv/q4k_fsub.sv
sv/q4k_datapath.sv
sv/q4k_ctrl.sv
sv/q4k_block_dequantizer.sv
tb/q4k_dequant_checker.sv
tb/tb_q4k_block_dequantizer.sv
